[rtl/core/scp_pkg.sv]
// Shared types, widths and constant tables for the stick cartesian-to-polar block.
// No dependencies; imported by every module of the block except scp_checker.
`default_nettype none
package scp_pkg;

   localparam int XY_WIDTH     = 32;
   localparam int Z_WIDTH      = 37;
   localparam int GUARD_BITS   = 12;
   localparam int ANGLE_LIMIT  = 25736;
   localparam int LENGTH_LIMIT = 65535;
   localparam logic signed [Z_WIDTH-1:0] PI_Q32 = 37'sd13493037704;

   typedef struct packed {
      logic signed [XY_WIDTH-1:0] cx;
      logic signed [XY_WIDTH-1:0] cy;
      logic signed [Z_WIDTH-1:0]  z;
   } rot_type;

   typedef struct packed {
      logic signed [15:0] x_flipped;
      logic signed [15:0] y_passed;
      logic               y_zero;
   } side_type;

   function automatic logic signed [Z_WIDTH-1:0] atan_lut(input logic [4:0] idx);
      logic signed [Z_WIDTH-1:0] val;
      unique case (idx)
         5'd0:    val = 37'sd3373259426;
         5'd1:    val = 37'sd1991351318;
         5'd2:    val = 37'sd1052175346;
         5'd3:    val = 37'sd534100635;
         5'd4:    val = 37'sd268086748;
         5'd5:    val = 37'sd134174063;
         5'd6:    val = 37'sd67103403;
         5'd7:    val = 37'sd33553749;
         5'd8:    val = 37'sd16777131;
         5'd9:    val = 37'sd8388597;
         5'd10:   val = 37'sd4194303;
         5'd11:   val = 37'sd2097152;
         5'd12:   val = 37'sd1048576;
         5'd13:   val = 37'sd524288;
         5'd14:   val = 37'sd262144;
         5'd15:   val = 37'sd131072;
         5'd16:   val = 37'sd65536;
         5'd17:   val = 37'sd32768;
         5'd18:   val = 37'sd16384;
         5'd19:   val = 37'sd8192;
         5'd20:   val = 37'sd4096;
         5'd21:   val = 37'sd2048;
         5'd22:   val = 37'sd1024;
         5'd23:   val = 37'sd512;
         default: val = '0;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] inv_gain_lut(input logic [4:0] stages);
      logic [31:0] val;
      unique case (stages)
         5'd8:    val = 32'd2608158028;
         5'd9:    val = 32'd2608138129;
         5'd10:   val = 32'd2608133154;
         5'd11:   val = 32'd2608131911;
         5'd12:   val = 32'd2608131600;
         5'd13:   val = 32'd2608131522;
         5'd14:   val = 32'd2608131503;
         5'd15:   val = 32'd2608131498;
         default: val = 32'd2608131496;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

[rtl/core/stick_cartesian_to_polar_top.sv]
// Path: input register, rotation stages (ROTATION_STAGES, clamped to 8..24), product register, result register.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while the result register is full and rsp_tready is low.
// Reset: synchronous, clears only the stage valid bits.
// Top level of the stick cartesian-to-polar pipeline.
// Depends on scp_pkg, scp_prep, scp_rotate and scp_scale.
`default_nettype none
module stick_cartesian_to_polar_top #(
   parameter int ROTATION_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] x_position, [31:16] y_position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [15:0] x_flipped, [31:16] y_passed,
                                    // [47:32] vector_length, [63:48] vector_angle
);
   import scp_pkg::*;

   localparam int STAGES_USED = (ROTATION_STAGES < 8) ? 8 :
                                ((ROTATION_STAGES > 24) ? 24 : ROTATION_STAGES);

   logic     advance;
   logic     valid_link [STAGES_USED+1];
   rot_type  rot_link   [STAGES_USED+1];
   side_type side_link  [STAGES_USED+1];

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   scp_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .valid_in   (req_tvalid),
      .x_position (req_tdata[15:0]),
      .y_position (req_tdata[31:16]),
      .valid_out  (valid_link[0]),
      .rot_out    (rot_link[0]),
      .side_out   (side_link[0])
   );

   for (genvar i = 0; i < STAGES_USED; i++) begin : g_rot
      scp_rotate #(.SHIFT(i)) u_rot (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (valid_link[i]),
         .rot_in    (rot_link[i]),
         .side_in   (side_link[i]),
         .valid_out (valid_link[i+1]),
         .rot_out   (rot_link[i+1]),
         .side_out  (side_link[i+1])
      );
   end

   scp_scale #(.STAGE_COUNT(STAGES_USED)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (valid_link[STAGES_USED]),
      .rot_in    (rot_link[STAGES_USED]),
      .side_in   (side_link[STAGES_USED]),
      .valid_out (rsp_tvalid),
      .result    (rsp_tdata)
   );
endmodule
`default_nettype wire

[rtl/core/scp_prep.sv]
// Input stage: saturating negate of x, quadrant fold and CORDIC seed.
// Depends on scp_pkg.
`default_nettype none
module scp_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              valid_in,
   input  logic signed [15:0] x_position,
   input  logic signed [15:0] y_position,
   output logic              valid_out,
   output scp_pkg::rot_type  rot_out,
   output scp_pkg::side_type side_out
);
   import scp_pkg::*;

   logic              valid_ff;
   rot_type           rot_ff, rot_in;
   side_type          side_ff, side_in;
   logic signed [15:0] xf;
   logic signed [XY_WIDTH-1:0] cx0, cy0;

   always_comb begin
      xf  = (x_position == 16'sh8000) ? 16'sh7FFF : -x_position;
      cx0 = XY_WIDTH'(xf) <<< GUARD_BITS;
      cy0 = XY_WIDTH'(y_position) <<< GUARD_BITS;
      side_in.x_flipped = xf;
      side_in.y_passed  = y_position;
      side_in.y_zero    = (y_position == 16'sd0);
      if (xf[15]) begin
         rot_in.cx = -cx0;
         rot_in.cy = -cy0;
         rot_in.z  = y_position[15] ? -PI_Q32 : PI_Q32;
      end else begin
         rot_in.cx = cx0;
         rot_in.cy = cy0;
         rot_in.z  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rot_ff  <= rot_in;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign rot_out   = rot_ff;
   assign side_out  = side_ff;
endmodule
`default_nettype wire

[rtl/core/scp_rotate.sv]
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// Depends on scp_pkg.
`default_nettype none
module scp_rotate #(
   parameter int SHIFT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              valid_in,
   input  scp_pkg::rot_type  rot_in,
   input  scp_pkg::side_type side_in,
   output logic              valid_out,
   output scp_pkg::rot_type  rot_out,
   output scp_pkg::side_type side_out
);
   import scp_pkg::*;

   localparam logic signed [Z_WIDTH-1:0] ANGLE_STEP = atan_lut(5'(SHIFT));

   logic     valid_ff;
   rot_type  rot_ff, rot_next;
   side_type side_ff;
   logic signed [XY_WIDTH-1:0] dx, dy;

   always_comb begin
      dx = rot_in.cy >>> SHIFT;
      dy = rot_in.cx >>> SHIFT;
      if (!rot_in.cy[XY_WIDTH-1]) begin
         rot_next.cx = rot_in.cx + dx;
         rot_next.cy = rot_in.cy - dy;
         rot_next.z  = rot_in.z + ANGLE_STEP;
      end else begin
         rot_next.cx = rot_in.cx - dx;
         rot_next.cy = rot_in.cy + dy;
         rot_next.z  = rot_in.z - ANGLE_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rot_ff  <= rot_next;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign rot_out   = rot_ff;
   assign side_out  = side_ff;
endmodule
`default_nettype wire

[rtl/core/scp_scale.sv]
// Gain correction multiply, rounding, clamping, the horizontal-axis override and the result register.
// Depends on scp_pkg.
`default_nettype none
module scp_scale #(
   parameter int STAGE_COUNT = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              valid_in,
   input  scp_pkg::rot_type  rot_in,
   input  scp_pkg::side_type side_in,
   output logic              valid_out,
   output logic [63:0]       result
);
   import scp_pkg::*;

   localparam logic [31:0] INV_GAIN = inv_gain_lut(5'(STAGE_COUNT));

   logic                      mul_valid_ff, out_valid_ff;
   logic [63:0]               prod_ff, prod_in;
   logic signed [Z_WIDTH-1:0] z_ff;
   side_type                  side_ff;
   logic [63:0]               out_ff, out_in;
   logic [63:0]               prod_rnd;
   logic [19:0]               len_wide;
   logic [15:0]               len;
   logic signed [Z_WIDTH-1:0] z_rnd;
   logic signed [17:0]        ang_wide;
   logic signed [15:0]        ang;
   logic [15:0]               x_abs;

   always_comb begin
      prod_in = rot_in.cx[XY_WIDTH-1] ? 64'd0
                : {32'd0, 32'(rot_in.cx)} * {32'd0, INV_GAIN};
   end

   always_comb begin
      prod_rnd = prod_ff + (64'd1 << 43);
      len_wide = prod_rnd[63:44];
      len      = (len_wide > 20'(LENGTH_LIMIT)) ? 16'(LENGTH_LIMIT) : len_wide[15:0];
      z_rnd    = z_ff + (Z_WIDTH'(1) <<< 18);
      ang_wide = 18'(z_rnd >>> 19);
      priority if (ang_wide > 18'sd25736) begin
         ang = 16'(ANGLE_LIMIT);
      end else if (ang_wide < -18'sd25736) begin
         ang = -16'(ANGLE_LIMIT);
      end else begin
         ang = ang_wide[15:0];
      end
      x_abs = side_ff.x_flipped[15] ? 16'(-side_ff.x_flipped) : side_ff.x_flipped;
      if (side_ff.y_zero) begin
         len = x_abs;
         ang = side_ff.x_flipped[15] ? 16'(ANGLE_LIMIT) : 16'sd0;
      end
      out_in = {ang, len, side_ff.y_passed, side_ff.x_flipped};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= valid_in;
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         z_ff    <= rot_in.z;
         side_ff <= side_in;
         out_ff  <= out_in;
      end
   end

   assign valid_out = out_valid_ff;
   assign result    = out_ff;
endmodule
`default_nettype wire

[rtl/core/scp_checker.sv]
// Port-level checks for the stick cartesian-to-polar top level, and its bind.
// Depends only on the top level's ports.
`default_nettype none
module scp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   logic signed [15:0] ang;
   assign ang = rsp_tdata[63:48];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   a_x_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] != 16'h8000)
      else $error("x_flipped not saturated");

   a_ang_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ang <= 16'sd25736 && ang >= -16'sd25736)
      else $error("angle out of range");

   a_axis_ang: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:16] == 16'd0 |->
         ang == 16'sd0 || ang == 16'sd25736)
      else $error("angle on horizontal axis wrong");
endmodule

bind stick_cartesian_to_polar_top scp_checker u_scp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
